FILE: hw/rtl/olad_pkg.sv
// ============================================================================
// olad_pkg
// Shared types and codes for the ordered list store: request actions,
// result status codes and the control word broadcast to the cell chain.
// ============================================================================
package olad_pkg;

    localparam int DATA_W   = 32;
    localparam int ACTION_W = 2;
    localparam int STATUS_W = 2;

    // Request actions.
    localparam logic [ACTION_W-1:0] ACT_APPEND = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_DUMP   = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY     = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd3;

    // Control word shared by every cell of the chain.
    typedef struct packed {
        logic append;
        logic remove;
        logic rotate;
    } cell_ctl_t;

endpackage

FILE: hw/rtl/olad_req_if.sv
// ============================================================================
// olad_req_if
// Request channel: valid/ready handshake carrying an action and a value.
// ============================================================================
interface olad_req_if;
    import olad_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [ACTION_W-1:0]      action;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);

endinterface

FILE: hw/rtl/olad_rsp_if.sv
// ============================================================================
// olad_rsp_if
// Result channel: valid/ready handshake carrying one result item.
// ============================================================================
interface olad_rsp_if;
    import olad_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] item;
    logic [STATUS_W-1:0]      status;
    logic                     last_of_run;

    modport source (output valid, output item, output status, output last_of_run,
                    input ready);
    modport sink   (input valid, input item, input status, input last_of_run,
                    output ready);

endinterface

FILE: hw/rtl/olad_cell.sv
// ============================================================================
// olad_cell
// One slot of the list. It compares its value with the search key, passes
// the "match seen" flag on to the next cell, and takes its neighbor's value
// when the list rotates or a deleted entry is squeezed out, and takes the key on an append to its slot.
// ============================================================================
module olad_cell (
    input  logic                               clk,
    input  olad_pkg::cell_ctl_t                ctl,
    input  logic                               wr_sel,
    input  logic                               live,
    input  logic signed [olad_pkg::DATA_W-1:0] key,
    input  logic signed [olad_pkg::DATA_W-1:0] nbr_data,
    input  logic                               found_in,
    output logic signed [olad_pkg::DATA_W-1:0] data,
    output logic                               found_out
);
    import olad_pkg::*;

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;
    logic                     hit;

    assign hit       = live && (data_reg == key);
    assign found_out = found_in || hit;
    assign data      = data_reg;

    always_comb
    begin
        data_next = data_reg;
        if (ctl.rotate || (ctl.remove && found_out))
        begin
            data_next = nbr_data;
        end
        else if (ctl.append && wr_sel)
        begin
            data_next = key;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

FILE: hw/rtl/ordered_list_append_delete_dump.sv
// ============================================================================
// ordered_list_append_delete_dump
// Bounded ordered list of signed values held in a chain of cells, head in
// cell 0. Supports append at tail, delete of the first match and dump.
// ============================================================================
// Append, delete and unused actions give their single result item in the
// cycle after acceptance; the search is one pass down the match chain.
// Dump emits one item per cycle while the sink takes them, then rotates the
// ring to its start; after accepting a dump the block stays busy until the
// ring has made a full turn, and longer whenever a dump item waits for the sink.
// Reset clears the entry count, the sequencer and the result valid flag; the
// cell contents are not reset and are never read before being written.
module ordered_list_append_delete_dump #(
    parameter int CAPACITY = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    olad_req_if.sink   req,
    olad_rsp_if.source rsp
);
    import olad_pkg::*;

    // The entry count must be able to hold CAPACITY itself.
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_DUMP = 2'b10
    } state_t;

    state_t state_reg, state_next;

    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;

    logic                     rsp_valid_reg, rsp_valid_next;
    logic signed [DATA_W-1:0] item_reg, item_next;
    logic [STATUS_W-1:0]      status_reg, status_next;
    logic                     last_reg, last_next;

    logic      slot_free;
    logic      req_fire;
    logic      emitting;
    logic      step;
    cell_ctl_t ctl;

    logic signed [DATA_W-1:0] cell_data [CAPACITY];
    logic                     found [CAPACITY+1];

    // The result register frees up when empty or when its item is taken.
    assign slot_free = !rsp_valid_reg || rsp.ready;
    assign req.ready = (state_reg == ST_IDLE) && slot_free;
    assign req_fire  = req.valid && req.ready;

    // During a dump the first count steps emit the head item, and the rest
    // just turn the ring so the list is back in place after CAPACITY steps.
    assign emitting = (state_reg == ST_DUMP) && (idx_reg < count_reg);
    assign step     = (state_reg == ST_DUMP) && (emitting ? slot_free : 1'b1);

    always_comb
    begin
        ctl.append = req_fire && (req.action == ACT_APPEND)
                     && (count_reg < CW'(CAPACITY));
        ctl.remove = req_fire && (req.action == ACT_REMOVE);
        ctl.rotate = step;
    end

    // Chain of cells. Each cell hands its value to the one before it, and
    // the head wraps around to the tail so a full ring rotation is lossless.
    assign found[0] = 1'b0;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        localparam int NXT = (i + 1) % CAPACITY;

        olad_cell u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .wr_sel    (count_reg == CW'(i)),
            .live      (CW'(i) < count_reg),
            .key       (req.value),
            .nbr_data  (cell_data[NXT]),
            .found_in  (found[i]),
            .data      (cell_data[i]),
            .found_out (found[i+1])
        );
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        rsp_valid_next = rsp_valid_reg;
        item_next      = item_reg;
        status_next    = status_reg;
        last_next      = last_reg;

        if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    rsp_valid_next = 1'b1;
                    item_next      = '0;
                    status_next    = STAT_OK;
                    last_next      = 1'b1;
                    case (req.action)
                        ACT_APPEND:
                        begin
                            if (count_reg < CW'(CAPACITY))
                            begin
                                count_next = count_reg + CW'(1);
                            end
                            else
                            begin
                                status_next = STAT_FULL;
                            end
                        end
                        ACT_REMOVE:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = STAT_EMPTY;
                            end
                            else if (found[CAPACITY])
                            begin
                                count_next = count_reg - CW'(1);
                            end
                            else
                            begin
                                status_next = STAT_NOT_FOUND;
                            end
                        end
                        ACT_DUMP:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                // Items come out of the sequencer instead.
                                rsp_valid_next = 1'b0;
                                idx_next       = '0;
                                state_next     = ST_DUMP;
                            end
                        end
                        default:
                        begin
                            // Unused action: one plain OK item, no change.
                        end
                    endcase
                end
            end
            ST_DUMP:
            begin
                if (step)
                begin
                    if (emitting)
                    begin
                        rsp_valid_next = 1'b1;
                        item_next      = cell_data[0];
                        status_next    = STAT_OK;
                        last_next      = (idx_reg == count_reg - CW'(1));
                    end
                    if (idx_reg == CW'(CAPACITY - 1))
                    begin
                        state_next = ST_IDLE;
                    end
                    idx_next = idx_reg + CW'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        status_reg <= status_next;
        last_reg   <= last_next;
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.item        = item_reg;
    assign rsp.status      = status_reg;
    assign rsp.last_of_run = last_reg;

endmodule

FILE: tb/ordered_list_append_delete_dump_tb.sv
// ============================================================================
// ordered_list_append_delete_dump_tb
// Self-checking bench for the ordered list store. Requests go in over the
// request channel and a shadow copy of the list predicts each result item.
// Every accepted result item is checked against the oldest prediction.
// Directed tests cover the empty store, the value extremes, duplicate values,
// a missing value, the unused action and overflow. Random traffic then fills
// and drains the store again and again, first gap-free, then with random gaps on both channels.
// ============================================================================
module ordered_list_append_delete_dump_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import olad_pkg::*;

    localparam int CAPACITY   = 16;
    localparam int IDLE_PCT   = 26;
    localparam int STALL_LIMIT = 2000;

    // The package defines no name for the fourth action code. The block must
    // answer it with a plain OK item and leave the list untouched.
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    // One result item as the block should emit it.
    typedef struct packed {
        logic signed [DATA_W-1:0] item;
        logic [STATUS_W-1:0]      status;
        logic                     last_of_run;
    } list_result_t;

    logic clk = 1'b0;
    logic rst_n;

    olad_req_if req_ch ();
    olad_rsp_if rsp_ch ();

    ordered_list_append_delete_dump #(
        .CAPACITY (CAPACITY)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Shadow of the stored values, head at index 0, and the result items
    // that the requests accepted so far have still to produce.
    logic signed [DATA_W-1:0] list_shadow[$];
    list_result_t             awaited_results[$];

    // When set, neither the sender nor the receiver inserts any gap.
    bit no_gaps;

    int requests_sent;
    int results_seen;
    int dump_items;
    int full_drops;
    int misses;
    int empty_reports;
    int mismatch_count;
    int quiet_cycles;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    function automatic void await_result(logic signed [DATA_W-1:0] item,
                                         logic [STATUS_W-1:0] status,
                                         logic last_of_run);
        list_result_t r;
        r.item        = item;
        r.status      = status;
        r.last_of_run = last_of_run;
        awaited_results.push_back(r);
    endfunction

    // Applies one accepted request to the shadow list and queues the result
    // items that it must produce.
    function automatic void apply_request(logic [ACTION_W-1:0] action,
                                          logic signed [DATA_W-1:0] value);
        int hit;
        hit = -1;
        case (action)
            ACT_APPEND:
            begin
                // A full store drops the value and says so.
                if (list_shadow.size() >= CAPACITY)
                    await_result('0, STAT_FULL, 1'b1);
                else
                begin
                    list_shadow.push_back(value);
                    await_result('0, STAT_OK, 1'b1);
                end
            end
            ACT_REMOVE:
            begin
                if (list_shadow.size() == 0)
                    await_result('0, STAT_EMPTY, 1'b1);
                else
                begin
                    // Only the first match from the head goes.
                    foreach (list_shadow[i])
                        if (hit < 0 && list_shadow[i] == value)
                            hit = i;
                    if (hit < 0)
                        await_result('0, STAT_NOT_FOUND, 1'b1);
                    else
                    begin
                        list_shadow.delete(hit);
                        await_result('0, STAT_OK, 1'b1);
                    end
                end
            end
            ACT_DUMP:
            begin
                if (list_shadow.size() == 0)
                    await_result('0, STAT_EMPTY, 1'b1);
                else
                begin
                    dump_items += list_shadow.size();
                    foreach (list_shadow[i])
                        await_result(list_shadow[i], STAT_OK,
                                     i == list_shadow.size() - 1);
                end
            end
            default:
                await_result('0, STAT_OK, 1'b1);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------
    // Presents one item and returns at the edge where it is accepted. Valid
    // stays high on return so that a following item can go back to back.
    task automatic send_request(input logic [ACTION_W-1:0] action,
                                input logic signed [DATA_W-1:0] value);
        while (!no_gaps && $urandom_range(0, 99) < IDLE_PCT)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid  <= 1'b1;
        req_ch.action <= action;
        req_ch.value  <= value;
        do
            @(posedge clk);
        while (!req_ch.ready);
        requests_sent++;
        apply_request(action, value);
    endtask

    // Values are drawn from a narrow pool often enough to make duplicates and
    // delete hits likely, and the extremes, zero and -1 are picked on purpose.
    function automatic logic signed [DATA_W-1:0] draw_value();
        logic signed [DATA_W-1:0] v;
        case ($urandom_range(0, 3))
            0:       v = int'($urandom_range(0, 7)) - 4;
            1:
            begin
                case ($urandom_range(0, 3))
                    0:       v = 32'sh8000_0000;
                    1:       v = 32'sh7FFF_FFFF;
                    2:       v = '0;
                    default: v = '1;
                endcase
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // ------------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------------
    always @(posedge clk)
        rsp_ch.ready <= no_gaps || ($urandom_range(0, 99) >= IDLE_PCT);

    always @(posedge clk)
    begin
        list_result_t want;
        list_result_t got;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got.item        = rsp_ch.item;
            got.status      = rsp_ch.status;
            got.last_of_run = rsp_ch.last_of_run;
            results_seen++;
            if (got.status == STAT_FULL)
                full_drops++;
            if (got.status == STAT_NOT_FOUND)
                misses++;
            if (got.status == STAT_EMPTY)
                empty_reports++;
            if (awaited_results.size() == 0)
            begin
                if (mismatch_count < 10)
                    $display("%0t: unexpected result item %0d status %0d last %0b",
                             $realtime, got.item, got.status, got.last_of_run);
                mismatch_count++;
            end
            else
            begin
                want = awaited_results.pop_front();
                if (got !== want)
                begin
                    if (mismatch_count < 10)
                    begin
                        $display("%0t: expected item %0d status %0d last %0b",
                                 $realtime, want.item, want.status, want.last_of_run);
                        $display("%0t:      got item %0d status %0d last %0b",
                                 $realtime, got.item, got.status, got.last_of_run);
                    end
                    mismatch_count++;
                end
            end
        end
    end

    // The run is stuck if neither channel moves an item for too long. A dump
    // keeps the block busy while the ring turns, but for far less than this limit.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no item moved for %0d cycles, %0d results outstanding",
                         $realtime, STALL_LIMIT, awaited_results.size());
                $display("ordered_list_append_delete_dump_tb: FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // An empty store: dump and delete report empty, the unused action code
    // gives a plain OK item.
    task automatic test_empty_store();
        send_request(ACT_DUMP, '0);
        send_request(ACT_REMOVE, 32'sh7FFF_FFFF);
        send_request(ACT_UNUSED, '1);
    endtask

    // The value extremes go through the list, the most negative value twice so
    // that only its first copy is deleted. A missing value is not found.
    task automatic test_extremes_and_duplicates();
        send_request(ACT_APPEND, 32'sh7FFF_FFFF);
        send_request(ACT_APPEND, 32'sh8000_0000);
        send_request(ACT_APPEND, '0);
        send_request(ACT_APPEND, '1);
        send_request(ACT_APPEND, 32'sh8000_0000);
        send_request(ACT_REMOVE, 32'sh8000_0000);
        send_request(ACT_REMOVE, 32'sd12345);
        send_request(ACT_DUMP, '0);
    endtask

    // Fill the store to capacity, push one more value that must be dropped,
    // then dump the full list.
    task automatic test_overflow();
        while (list_shadow.size() < CAPACITY)
            send_request(ACT_APPEND, $urandom);
        send_request(ACT_APPEND, 32'sh5555_AAAA);
        send_request(ACT_DUMP, '0);
    endtask

    // Mostly well-formed traffic: the list swings between empty and full,
    // deletes mostly name a stored value, and dumps read it out at every size.
    // The rest is deletes of random values and the unused action code.
    task automatic test_random_traffic(input int n_items);
        int  pick;
        bit  growing;
        growing = 1'b1;
        repeat (n_items)
        begin
            if (list_shadow.size() >= CAPACITY)
                growing = ($urandom_range(0, 3) == 0);
            else if (list_shadow.size() == 0)
                growing = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 10)
                send_request(ACT_DUMP, draw_value());
            else if (pick < 14)
                send_request(ACT_UNUSED, draw_value());
            else if (pick < 20)
                send_request(ACT_REMOVE, draw_value());
            else if ((pick < 65) == growing)
                send_request(ACT_APPEND, draw_value());
            else if (list_shadow.size() != 0)
                send_request(ACT_REMOVE,
                             list_shadow[$urandom_range(0, list_shadow.size() - 1)]);
            else
                send_request(ACT_REMOVE, draw_value());
        end
    endtask

    // The same traffic with no gaps on either channel.
    task automatic test_back_to_back(input int n_items);
        no_gaps = 1'b1;
        test_random_traffic(n_items);
        no_gaps = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n         = 1'b0;
        req_ch.valid  = 1'b0;
        req_ch.action = ACT_APPEND;
        req_ch.value  = '0;
        rsp_ch.ready  = 1'b0;
        no_gaps       = 1'b0;
        quiet_cycles  = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_store();
        test_extremes_and_duplicates();
        test_overflow();
        test_back_to_back(40);
        test_random_traffic(160);
        req_ch.valid <= 1'b0;

        // Drain what is still owed, then give the block time to show any
        // stray result item after the last one expected.
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (CAPACITY + 8) @(posedge clk);

        $display("Sent %0d requests and checked %0d result items (%0d dump entries).",
                 requests_sent, results_seen, dump_items);
        $display("Saw %0d dropped appends, %0d values not found, %0d empty reports.",
                 full_drops, misses, empty_reports);
        if (mismatch_count == 0)
            $display("ordered_list_append_delete_dump_tb: PASS");
        else
        begin
            $display("%0d mismatches", mismatch_count);
            $display("ordered_list_append_delete_dump_tb: FAIL");
        end
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/olad_pkg.sv
hw/rtl/olad_req_if.sv
hw/rtl/olad_rsp_if.sv
hw/rtl/olad_cell.sv
hw/rtl/ordered_list_append_delete_dump.sv
tb/ordered_list_append_delete_dump_tb.sv
